// File: rtl/bwe_pkg.sv
`timescale 1ns / 1ps

package bwe_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_START_TIME   = 3'd0,
    REG_END_TIME     = 3'd1,
    REG_START_WEIGHT = 3'd2,
    REG_END_WEIGHT   = 3'd3,
    REG_SMOOTHNESS   = 3'd4
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned SMOOTH_W   = 17;

  // Quotient bits of the fraction, one divider stage each
  localparam int unsigned DIV_BITS   = 16;

  // Register stages from request to result: input, divider, arithmetic
  localparam int unsigned PIPE_DEPTH = 1 + DIV_BITS + 8;
  localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH + 1);

  // Unity in Q1.16 and the lowest smoothness that enables the cubic mix
  localparam logic [SMOOTH_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [SMOOTH_W-1:0] SMOOTH_MIN = 17'd7;

endpackage

// File: rtl/bwe_time_if.sv
`timescale 1ns / 1ps

interface bwe_time_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink   (input valid, input now_time, output ready);
endinterface

// File: rtl/bwe_weight_if.sv
`timescale 1ns / 1ps

interface bwe_weight_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] weight;

  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

// File: rtl/blend_weight_envelope_top.sv
// Blend weight envelope: each request carries a Q16.16 time and returns one
// Q2.14 weight. Times at or before start_time give start_weight, times at or
// after end_time give end_weight; in between the fraction
// x = (t - start) / (end - start) drives a linear ramp mixed with a cubic
// smoothstep by the smoothness register (values above one act as one, values
// below 7/65536 give the plain ramp). The block is a 25-stage pipeline: a
// request is taken every cycle while no stalled result backs up the pipeline,
// and its result passes through the 16-stage restoring divider (one quotient bit per
// stage) and the eight stages of the multiply chain behind it. A stalled
// result holds only the last stage; empty stages further up keep taking
// requests. Write the configuration only while no request is in flight.
`timescale 1ns / 1ps

module blend_weight_envelope_top
  import bwe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bwe_time_if.sink              req_i,
  bwe_weight_if.source          rsp_o
);

  typedef enum logic [1:0] {
    MODE_START,
    MODE_END,
    MODE_RAMP
  } mode_e;

  // Stage positions behind the divider
  localparam int unsigned ST_DIV_LAST = DIV_BITS;
  localparam int unsigned ST_PROD1    = ST_DIV_LAST + 1;
  localparam int unsigned ST_X2       = ST_DIV_LAST + 2;
  localparam int unsigned ST_PROD3    = ST_DIV_LAST + 3;
  localparam int unsigned ST_H        = ST_DIV_LAST + 4;
  localparam int unsigned ST_PRODH    = ST_DIV_LAST + 5;
  localparam int unsigned ST_CUB      = ST_DIV_LAST + 6;
  localparam int unsigned ST_MIX      = ST_DIV_LAST + 7;
  localparam int unsigned ST_OUT      = ST_DIV_LAST + 8;
  localparam int unsigned LIN_N       = ST_MIX - ST_X2 + 1;

  function automatic logic signed [WEIGHT_W-1:0] sat16(input logic signed [21:0] v);
    logic signed [WEIGHT_W-1:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[WEIGHT_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  logic signed [TIME_W-1:0]   start_time_q, end_time_q;
  logic signed [WEIGHT_W-1:0] start_weight_q, end_weight_q;
  logic [SMOOTH_W-1:0]        smoothness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q   <= '0;
      end_time_q     <= '0;
      start_weight_q <= 16'sd16384;
      end_weight_q   <= 16'sd16384;
      smoothness_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_START_TIME:   start_time_q   <= cfg_wdata_i[TIME_W-1:0];
        REG_END_TIME:     end_time_q     <= cfg_wdata_i[TIME_W-1:0];
        REG_START_WEIGHT: start_weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
        REG_END_WEIGHT:   end_weight_q   <= cfg_wdata_i[WEIGHT_W-1:0];
        REG_SMOOTHNESS:   smoothness_q   <= cfg_wdata_i[SMOOTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived values: user, not block, keeps them static while requests are in flight
  logic [TIME_W:0]          den_full;
  logic [TIME_W-1:0]        den;
  logic signed [16:0]       dw;
  logic [SMOOTH_W-1:0]      smc, inv;
  logic                     sm_small;

  assign den_full = {end_time_q[TIME_W-1], end_time_q}
                  - {start_time_q[TIME_W-1], start_time_q};
  assign den      = den_full[TIME_W-1:0];
  assign dw       = $signed({end_weight_q[WEIGHT_W-1], end_weight_q})
                  - $signed({start_weight_q[WEIGHT_W-1], start_weight_q});
  assign smc      = (smoothness_q > ONE_Q16) ? ONE_Q16 : smoothness_q;
  assign inv      = ONE_Q16 - smc;
  assign sm_small = (smc < SMOOTH_MIN);

  // ---------------------------------------------------------------------
  // Stage valids and enables: a stage loads when it is empty or moves on
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] en;

  assign en[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || rsp_o.ready;
  for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign req_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Region of each request travels with it
  mode_e mode_q [PIPE_DEPTH];
  mode_e mode_d;

  always_comb begin
    if (req_i.now_time <= start_time_q) begin
      mode_d = MODE_START;
    end else if (req_i.now_time >= end_time_q) begin
      mode_d = MODE_END;
    end else begin
      mode_d = MODE_RAMP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode_q[0] <= mode_d;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (en[k]) begin
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: numerator of the fraction (below den inside the ramp)
  logic [TIME_W-1:0] rem_q [DIV_BITS+1];
  logic [15:0]       quo_q [DIV_BITS+1];
  logic [TIME_W:0]   num_full;

  assign num_full = {req_i.now_time[TIME_W-1], req_i.now_time}
                  - {start_time_q[TIME_W-1], start_time_q};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0] <= num_full[TIME_W-1:0];
      quo_q[0] <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
    logic [TIME_W:0]   shifted;
    logic [TIME_W+1:0] diff;
    logic              take;

    assign shifted = {rem_q[k-1], 1'b0};
    assign diff    = {1'b0, shifted} - {2'b00, den};
    assign take    = !diff[TIME_W+1];

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= take ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
        quo_q[k] <= {quo_q[k-1][14:0], take};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Arithmetic chain
  logic signed [33:0] pdx_q, pdx_r;
  logic [31:0]        pxx_q;
  logic [15:0]        x17_q, x18_q;
  logic [32:0]        pxx_r;
  logic [16:0]        x2_q, x2b_q;
  logic signed [17:0] lin_q [LIN_N];
  logic signed [17:0] lin_d;
  logic [32:0]        p3_q;
  logic [33:0]        p3_r;
  logic [17:0]        x3;
  logic [19:0]        h_u;
  logic signed [19:0] h_q;
  logic signed [36:0] pdh_q, pdh_r;
  logic signed [20:0] cub_full;
  logic signed [18:0] cub_q;
  logic signed [36:0] pa_q, pb_q;
  logic signed [37:0] mix_sum, mix_r;
  logic signed [21:0] w_mix;
  logic signed [WEIGHT_W-1:0] weight_q, weight_d;

  // d*x and x*x
  always_ff @(posedge clk_i) begin
    if (en[ST_PROD1]) begin
      pdx_q <= dw * $signed({1'b0, quo_q[ST_DIV_LAST]});
      pxx_q <= quo_q[ST_DIV_LAST] * quo_q[ST_DIV_LAST];
      x17_q <= quo_q[ST_DIV_LAST];
    end
  end

  // Round: linear ramp and x^2
  assign pdx_r = pdx_q + 34'sd32768;
  assign lin_d = $signed({{2{start_weight_q[WEIGHT_W-1]}}, start_weight_q})
               + $signed(pdx_r[33:16]);
  assign pxx_r = {1'b0, pxx_q} + 33'd32768;

  always_ff @(posedge clk_i) begin
    if (en[ST_X2]) begin
      lin_q[0] <= lin_d;
      x2_q     <= pxx_r[32:16];
      x18_q    <= x17_q;
    end
  end

  // Ramp value rides alongside the cubic terms
  for (genvar k = 1; k < LIN_N; k++) begin : g_lin
    always_ff @(posedge clk_i) begin
      if (en[ST_X2+k]) begin
        lin_q[k] <= lin_q[k-1];
      end
    end
  end

  // x^2 * x
  always_ff @(posedge clk_i) begin
    if (en[ST_PROD3]) begin
      p3_q  <= x2_q * x18_q;
      x2b_q <= x2_q;
    end
  end

  // h = 3x^2 - 2x^3
  assign p3_r = {1'b0, p3_q} + 34'd32768;
  assign x3   = p3_r[33:16];
  assign h_u  = {2'b00, x2b_q, 1'b0} + {3'b000, x2b_q} - {1'b0, x3, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en[ST_H]) begin
      h_q <= $signed(h_u);
    end
  end

  // d*h
  always_ff @(posedge clk_i) begin
    if (en[ST_PRODH]) begin
      pdh_q <= dw * h_q;
    end
  end

  // Cubic curve value
  assign pdh_r    = pdh_q + 37'sd32768;
  assign cub_full = $signed({{5{start_weight_q[WEIGHT_W-1]}}, start_weight_q})
                  + $signed(pdh_r[36:16]);

  always_ff @(posedge clk_i) begin
    if (en[ST_CUB]) begin
      cub_q <= cub_full[18:0];
    end
  end

  // Weighted terms of the mix
  always_ff @(posedge clk_i) begin
    if (en[ST_MIX]) begin
      pa_q <= $signed({1'b0, smc}) * cub_q;
      pb_q <= $signed({1'b0, inv}) * lin_q[LIN_N-2];
    end
  end

  // Mix, round, saturate and pick by region
  assign mix_sum = pa_q + pb_q;
  assign mix_r   = mix_sum + 38'sd32768;
  assign w_mix   = $signed(mix_r[37:16]);

  always_comb begin
    case (mode_q[ST_MIX])
      MODE_START: weight_d = start_weight_q;
      MODE_END:   weight_d = end_weight_q;
      MODE_RAMP:  weight_d = sm_small ? sat16(22'(lin_q[LIN_N-1])) : sat16(w_mix);
      default:    weight_d = start_weight_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      weight_q <= weight_d;
    end
  end

  assign rsp_o.valid  = vld_q[ST_OUT];
  assign rsp_o.weight = weight_q;

endmodule

// File: rtl/bwe_checker.sv
`timescale 1ns / 1ps

module bwe_checker
  import bwe_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [WEIGHT_W-1:0] out_weight_i
);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Requests accepted whose results are not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // A result never appears without a request behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cnt_q != '0))
    else $error("result without an outstanding request");

  // The pipeline never holds more than one request per stage
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  // With no result waiting, the pipeline has room
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request refused while the output is empty");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_weight_i)))
    else $error("stalled result dropped or changed");

endmodule

bind blend_weight_envelope_top bwe_checker u_bwe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_weight_i (rsp_o.weight)
);
